@@ hdl/swdgm_pkg.sv @@
// Shared constants, types and microcode table for the wet/dry gain mixer.
`timescale 1ns / 1ps
package swdgm_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int NUM_GAINS   = 6;
    localparam int GAIN_W      = 18;
    localparam int SUM_W       = 20;
    localparam int RATIO_W     = 17;
    localparam int STEP_W      = 25;
    localparam int GACC_W      = 23;
    localparam int PHI_W       = 20;
    localparam int MONO_W      = SAMPLE_BITS + 1;
    localparam int MUL_W       = (MONO_W + 1 > STEP_W + 1) ? MONO_W + 1 : STEP_W + 1;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int FRAC_W      = 16;
    localparam int STEP_FRAC   = 24;
    localparam int ROUND_SHIFT = 17;
    localparam int UPC_W       = 3;
    localparam int K_W         = 3;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;

    localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1 << STEP_FRAC);
    localparam logic [K_W-1:0]    K_LAST   = K_W'(NUM_GAINS - 1);

    // gain slots
    localparam int G_WET_A = 0;
    localparam int G_WET_B = 1;
    localparam int G_WET_C = 2;
    localparam int G_DRY   = 3;
    localparam int G_DIR   = 4;
    localparam int G_ATT   = 5;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << FRAC_W);

    // register map (word index)
    localparam logic [2:0] REG_TGT_WET_A = 3'd0;
    localparam logic [2:0] REG_TGT_WET_B = 3'd1;
    localparam logic [2:0] REG_TGT_WET_C = 3'd2;
    localparam logic [2:0] REG_WET_RATIO = 3'd3;
    localparam logic [2:0] REG_TGT_DRY   = 3'd4;
    localparam logic [2:0] REG_TGT_DIR   = 3'd5;
    localparam logic [2:0] REG_TGT_ATT   = 3'd6;
    localparam logic [2:0] REG_LERP_STEP = 3'd7;

    // multiplier operand selects
    localparam logic [2:0] A_WSUM = 3'd0;
    localparam logic [2:0] A_DRY  = 3'd1;
    localparam logic [2:0] A_PHI  = 3'd2;
    localparam logic [2:0] A_MONO = 3'd3;
    localparam logic [2:0] A_ABS  = 3'd4;

    localparam logic [2:0] B_RATIO = 3'd0;
    localparam logic [2:0] B_DIR   = 3'd1;
    localparam logic [2:0] B_ATT   = 3'd2;
    localparam logic [2:0] B_GAIN  = 3'd3;
    localparam logic [2:0] B_STEP  = 3'd4;

    // gain accumulator ops
    localparam logic [1:0] G_HOLD = 2'd0;
    localparam logic [1:0] G_LOAD = 2'd1;
    localparam logic [1:0] G_ADD  = 2'd2;

    // sequencing
    localparam logic [1:0] JMP_NEXT = 2'd0;
    localparam logic [1:0] JMP_LOOP = 2'd1;
    localparam logic [1:0] JMP_END  = 2'd2;

    typedef struct packed {
        logic [2:0]       a_sel;
        logic [2:0]       b_sel;
        logic             mul_en;
        logic [1:0]       g_op;
        logic             out_wr;
        logic             upd;
        logic [1:0]       jmp;
        logic [UPC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic           fire;
        uword_t         uw;
        logic [K_W-1:0] k;
    } dp_ctl_t;

    typedef struct packed {
        logic [NUM_GAINS-1:0][GAIN_W-1:0] target;
        logic [RATIO_W-1:0]               wet_ratio;
        logic [STEP_W-1:0]                lerp_step;
    } cfg_t;

    function automatic uword_t uw_make(
        input logic [2:0]       a_sel,
        input logic [2:0]       b_sel,
        input logic             mul_en,
        input logic [1:0]       g_op,
        input logic             out_wr,
        input logic             upd,
        input logic [1:0]       jmp,
        input logic [UPC_W-1:0] target
    );
        uword_t uw;
        uw.a_sel  = a_sel;
        uw.b_sel  = b_sel;
        uw.mul_en = mul_en;
        uw.g_op   = g_op;
        uw.out_wr = out_wr;
        uw.upd    = upd;
        uw.jmp    = jmp;
        uw.target = target;
        return uw;
    endfunction

    // Program: gain = ratio*wsum>>16 + ((dry*dir>>16)*att>>16), out = mono*gain,
    // then a two-step loop glides each of the six gains.
    function automatic uword_t ucode_rom(input logic [UPC_W-1:0] addr);
        uword_t uw;
        unique case (addr)
            3'd0:    uw = uw_make(A_WSUM, B_RATIO, 1'b1, G_HOLD, 1'b0, 1'b0, JMP_NEXT, 3'd0);
            3'd1:    uw = uw_make(A_DRY,  B_DIR,   1'b1, G_LOAD, 1'b0, 1'b0, JMP_NEXT, 3'd0);
            3'd2:    uw = uw_make(A_PHI,  B_ATT,   1'b1, G_HOLD, 1'b0, 1'b0, JMP_NEXT, 3'd0);
            3'd3:    uw = uw_make(A_WSUM, B_RATIO, 1'b0, G_ADD,  1'b0, 1'b0, JMP_NEXT, 3'd0);
            3'd4:    uw = uw_make(A_MONO, B_GAIN,  1'b1, G_HOLD, 1'b0, 1'b0, JMP_NEXT, 3'd0);
            3'd5:    uw = uw_make(A_WSUM, B_RATIO, 1'b0, G_HOLD, 1'b1, 1'b0, JMP_NEXT, 3'd0);
            3'd6:    uw = uw_make(A_ABS,  B_STEP,  1'b1, G_HOLD, 1'b0, 1'b0, JMP_NEXT, 3'd0);
            3'd7:    uw = uw_make(A_WSUM, B_RATIO, 1'b0, G_HOLD, 1'b0, 1'b1, JMP_LOOP, 3'd6);
            default: uw = uw_make(A_WSUM, B_RATIO, 1'b0, G_HOLD, 1'b0, 1'b0, JMP_END,  3'd0);
        endcase
        return uw;
    endfunction

endpackage

@@ hdl/smoothed_wet_dry_gain_mixer_core.sv @@
// Smoothed wet/dry gain mixer: top level.
//
// Input: s_valid/s_ready carry one stereo pair (s_left_sample,
// s_right_sample). Output: m_valid/m_ready carry one saturated mono sample
// (m_out_sample) that serves both channels. Settings sit in an APB register
// file: three reverb band gain targets, wet ratio, dry, directivity and
// attenuation targets, and the glide step.
// Each transfer runs an 8-step microprogram on one shared multiplier: five
// multiply/accumulate steps form the gain and the product, one step writes
// the result, then two steps per gain glide the six current gains.
// The result is registered at the output step; a new pair is taken only
// after the program for the previous one has ended, since the shared
// multiplier also runs the six-gain glide loop.
// s_ready is high only while the program is idle.
// Reset (aresetn low, synchronous) restores register defaults and gains,
// drops m_valid and stops the program.
// A stalled receiver holds the result register; the program waits at its
// output step until the slot frees, so nothing is dropped.
`timescale 1ns / 1ps
module smoothed_wet_dry_gain_mixer_core
    import swdgm_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_left_sample,
    input  logic signed [SAMPLE_BITS-1:0] s_right_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_out_sample,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ADDR_W-1:0]             paddr,
    input  logic [DATA_W-1:0]             pwdata,
    output logic [DATA_W-1:0]             prdata,
    output logic                          pready
);

    cfg_t    cfg;
    dp_ctl_t ctl;
    logic    busy;
    logic    start;
    logic    out_free;

    assign s_ready = !busy;
    assign start   = s_valid && s_ready;

    swdgm_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    swdgm_useq u_useq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .out_free (out_free),
        .ctl      (ctl),
        .busy     (busy)
    );

    swdgm_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (start),
        .left_sample  (s_left_sample),
        .right_sample (s_right_sample),
        .cfg          (cfg),
        .ctl          (ctl),
        .out_free     (out_free),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_sample (m_out_sample)
    );

endmodule

@@ hdl/swdgm_cfg_regs.sv @@
// APB register file holding gain targets, wet ratio and glide step.
`timescale 1ns / 1ps
module swdgm_cfg_regs
    import swdgm_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                REG_TGT_WET_A: cfg_next.target[G_WET_A] = pwdata[GAIN_W-1:0];
                REG_TGT_WET_B: cfg_next.target[G_WET_B] = pwdata[GAIN_W-1:0];
                REG_TGT_WET_C: cfg_next.target[G_WET_C] = pwdata[GAIN_W-1:0];
                REG_WET_RATIO: cfg_next.wet_ratio       = pwdata[RATIO_W-1:0];
                REG_TGT_DRY:   cfg_next.target[G_DRY]   = pwdata[GAIN_W-1:0];
                REG_TGT_DIR:   cfg_next.target[G_DIR]   = GAIN_W'(pwdata[RATIO_W-1:0]);
                REG_TGT_ATT:   cfg_next.target[G_ATT]   = GAIN_W'(pwdata[RATIO_W-1:0]);
                REG_LERP_STEP: cfg_next.lerp_step       = pwdata[STEP_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target[G_WET_A] <= GAIN_ONE;
            cfg_reg.target[G_WET_B] <= '0;
            cfg_reg.target[G_WET_C] <= '0;
            cfg_reg.target[G_DRY]   <= GAIN_ONE;
            cfg_reg.target[G_DIR]   <= GAIN_ONE;
            cfg_reg.target[G_ATT]   <= GAIN_ONE;
            cfg_reg.wet_ratio       <= RATIO_W'(6554);
            cfg_reg.lerp_step       <= STEP_W'(8192);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        unique case (idx)
            REG_TGT_WET_A: prdata = DATA_W'(cfg_reg.target[G_WET_A]);
            REG_TGT_WET_B: prdata = DATA_W'(cfg_reg.target[G_WET_B]);
            REG_TGT_WET_C: prdata = DATA_W'(cfg_reg.target[G_WET_C]);
            REG_WET_RATIO: prdata = DATA_W'(cfg_reg.wet_ratio);
            REG_TGT_DRY:   prdata = DATA_W'(cfg_reg.target[G_DRY]);
            REG_TGT_DIR:   prdata = DATA_W'(cfg_reg.target[G_DIR]);
            REG_TGT_ATT:   prdata = DATA_W'(cfg_reg.target[G_ATT]);
            REG_LERP_STEP: prdata = DATA_W'(cfg_reg.lerp_step);
            default:       prdata = '0;
        endcase
    end

endmodule

@@ hdl/swdgm_useq.sv @@
// Microcode sequencer: step counter, control ROM, gain loop counter.
`timescale 1ns / 1ps
module swdgm_useq
    import swdgm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    start,
    input  logic    out_free,
    output dp_ctl_t ctl,
    output logic    busy
);

    logic             busy_reg;
    logic             busy_next;
    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic [K_W-1:0]   k_reg;
    logic [K_W-1:0]   k_next;
    uword_t           uw;
    logic             stall;
    logic             fire;

    assign uw    = ucode_rom(upc_reg);
    // the output step waits for a free result slot
    assign stall = uw.out_wr && !out_free;
    assign fire  = busy_reg && !stall;

    assign ctl.fire = fire;
    assign ctl.uw   = uw;
    assign ctl.k    = k_reg;
    assign busy     = busy_reg;

    always_comb begin
        busy_next = busy_reg;
        upc_next  = upc_reg;
        k_next    = k_reg;
        if (start) begin
            busy_next = 1'b1;
            upc_next  = '0;
            k_next    = '0;
        end else if (fire) begin
            if (uw.upd) begin
                k_next = (k_reg == K_LAST) ? '0 : k_reg + K_W'(1);
            end
            unique case (uw.jmp)
                JMP_NEXT: upc_next = upc_reg + UPC_W'(1);
                JMP_LOOP: begin
                    if (k_reg != K_LAST) begin
                        upc_next = uw.target;
                    end else begin
                        busy_next = 1'b0;
                    end
                end
                JMP_END:  busy_next = 1'b0;
                default:  busy_next = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            upc_reg  <= '0;
            k_reg    <= '0;
        end else begin
            busy_reg <= busy_next;
            upc_reg  <= upc_next;
            k_reg    <= k_next;
        end
    end

    a_k_range: assert property (@(posedge aclk) disable iff (!aresetn)
        k_reg <= K_LAST)
        else $error("gain loop index out of range");

    a_start_step0: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy_reg && upc_reg == '0 && k_reg == '0)
        else $error("program did not start at step zero");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && uw.out_wr && !out_free |=> busy_reg && $stable(upc_reg))
        else $error("output step advanced without a free slot");

endmodule

@@ hdl/swdgm_datapath.sv @@
// Shared multiplier, gain accumulator, current gains and output register.
`timescale 1ns / 1ps
module swdgm_datapath
    import swdgm_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  logic signed [SAMPLE_BITS-1:0] left_sample,
    input  logic signed [SAMPLE_BITS-1:0] right_sample,
    input  cfg_t                          cfg,
    input  dp_ctl_t                       ctl,
    output logic                          out_free,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_out_sample
);

    localparam int HEAD_W = PROD_W - SAMPLE_BITS + 1;

    logic signed [MONO_W-1:0]      mono_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [PROD_W-1:0]      prod_next;
    logic        [GACC_W-1:0]      gacc_reg;
    logic        [GAIN_W-1:0]      gain_reg [NUM_GAINS];
    logic                          m_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg;

    logic        [SUM_W-1:0]       wsum;
    logic        [STEP_W-1:0]      step_c;
    logic signed [MUL_W-1:0]       op_a;
    logic signed [MUL_W-1:0]       op_b;
    logic        [GAIN_W-1:0]      now_k;
    logic        [GAIN_W-1:0]      tgt_k;
    logic signed [GAIN_W:0]        diff;
    logic        [GAIN_W-1:0]      absdiff;
    logic        [GAIN_W-1:0]      mag;
    logic        [GAIN_W-1:0]      delta;
    logic        [GAIN_W-1:0]      glided;
    logic signed [PROD_W-1:0]      rounded;
    logic signed [PROD_W-1:0]      shifted;
    logic        [HEAD_W-1:0]      head;
    logic signed [SAMPLE_BITS-1:0] sat;

    assign wsum   = SUM_W'(gain_reg[G_WET_A]) + SUM_W'(gain_reg[G_WET_B])
                  + SUM_W'(gain_reg[G_WET_C]);
    assign step_c = (cfg.lerp_step > STEP_ONE) ? STEP_ONE : cfg.lerp_step;

    // glide of gain k toward its target
    assign now_k   = gain_reg[ctl.k];
    assign tgt_k   = cfg.target[ctl.k];
    assign diff    = $signed({1'b0, tgt_k}) - $signed({1'b0, now_k});
    assign absdiff = diff[GAIN_W] ? GAIN_W'(-diff) : GAIN_W'(diff);
    assign mag     = prod_reg[STEP_FRAC +: GAIN_W];
    assign delta   = (mag == '0) ? GAIN_W'(1) : mag;
    assign glided  = diff[GAIN_W] ? now_k - delta : now_k + delta;

    always_comb begin
        unique case (ctl.uw.a_sel)
            A_WSUM:  op_a = MUL_W'(wsum);
            A_DRY:   op_a = MUL_W'(gain_reg[G_DRY]);
            A_PHI:   op_a = MUL_W'(prod_reg[FRAC_W +: PHI_W]);
            A_MONO:  op_a = MUL_W'(mono_reg);
            A_ABS:   op_a = MUL_W'(absdiff);
            default: op_a = '0;
        endcase
        unique case (ctl.uw.b_sel)
            B_RATIO: op_b = MUL_W'(cfg.wet_ratio);
            B_DIR:   op_b = MUL_W'(gain_reg[G_DIR]);
            B_ATT:   op_b = MUL_W'(gain_reg[G_ATT]);
            B_GAIN:  op_b = MUL_W'(gacc_reg);
            B_STEP:  op_b = MUL_W'(step_c);
            default: op_b = '0;
        endcase
    end

    assign prod_next = op_a * op_b;

    // round half up, then saturate to the sample width
    assign rounded = prod_reg + PROD_W'(1 << (ROUND_SHIFT - 1));
    assign shifted = rounded >>> ROUND_SHIFT;
    assign head    = shifted[PROD_W-1:SAMPLE_BITS-1];
    always_comb begin
        if (&head || ~|head) begin
            sat = shifted[SAMPLE_BITS-1:0];
        end else if (shifted[PROD_W-1]) begin
            sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            mono_reg <= MONO_W'(left_sample) + MONO_W'(right_sample);
        end
        if (ctl.fire && ctl.uw.mul_en) begin
            prod_reg <= prod_next;
        end
        if (ctl.fire) begin
            unique case (ctl.uw.g_op)
                G_HOLD:  gacc_reg <= gacc_reg;
                G_LOAD:  gacc_reg <= prod_reg[FRAC_W +: GACC_W];
                G_ADD:   gacc_reg <= gacc_reg + prod_reg[FRAC_W +: GACC_W];
                default: gacc_reg <= gacc_reg;
            endcase
        end
        if (ctl.fire && ctl.uw.out_wr) begin
            out_reg <= sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg[G_WET_A] <= GAIN_ONE;
            gain_reg[G_WET_B] <= '0;
            gain_reg[G_WET_C] <= '0;
            gain_reg[G_DRY]   <= GAIN_ONE;
            gain_reg[G_DIR]   <= GAIN_ONE;
            gain_reg[G_ATT]   <= GAIN_ONE;
            m_valid_reg       <= 1'b0;
        end else begin
            if (ctl.fire && ctl.uw.upd && diff != '0 && cfg.lerp_step != '0) begin
                gain_reg[ctl.k] <= glided;
            end
            if (ctl.fire && ctl.uw.out_wr) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign out_free     = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_out_sample = out_reg;

    a_out_written: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.fire && ctl.uw.out_wr |=> m_valid_reg)
        else $error("result write did not raise valid");

    a_write_free_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.fire && ctl.uw.out_wr |-> out_free)
        else $error("result written over a waiting transfer");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(out_reg))
        else $error("stalled result changed or dropped");

endmodule
